[hdl/rtdh_pkg.sv]
// Shared constants, codes and types for the ring time-difference histogram.
`timescale 1ns / 1ps
package rtdh_pkg;

  localparam int RINGS_DEFAULT = 24;
  localparam int BINS_DEFAULT  = 32768;

  localparam int RING_IN_W   = 6;
  localparam int TIME_W      = 24;
  localparam int TS_W        = 20;
  localparam int TS_SHIFT    = 4;    // timestamp is scaled by 16
  localparam int BIN_INDEX_W = 15;
  localparam int READ_BIN_W  = 15;
  localparam int COUNT_W     = 32;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef enum logic {
    OP_ACCUM = 1'b0,
    OP_READ  = 1'b1
  } op_t;

  typedef enum logic {
    ST_CLEAR,
    ST_RUN
  } state_t;

  typedef struct packed {
    op_t                   operation;
    logic [RING_IN_W-1:0]  ring;
    logic                  ring_hit;
    logic                  fold_positive;
    logic [TIME_W-1:0]     cfd_time;
    logic [TS_W-1:0]       timestamp;
    logic                  rf_present;
    logic [TIME_W-1:0]     rf_time;
    logic [READ_BIN_W-1:0] read_bin;
  } req_t;

endpackage

[hdl/rtdh_if.sv]
// Request and response channel interfaces.
`timescale 1ns / 1ps
interface rtdh_req_if;
  import rtdh_pkg::*;

  logic                         valid;
  logic                         ready;
  op_t                          operation;
  logic [RING_IN_W-1:0]         ring;
  logic                         ring_hit;
  logic                         fold_positive;
  logic [TIME_W-1:0]            cfd_time;
  logic [TS_W-1:0]              timestamp;
  logic                         rf_present;
  logic signed [TIME_W-1:0]     rf_time;
  logic [READ_BIN_W-1:0]        read_bin;

  modport source (
    output valid, operation, ring, ring_hit, fold_positive, cfd_time, timestamp,
           rf_present, rf_time, read_bin,
    input  ready
  );
  modport sink (
    input  valid, operation, ring, ring_hit, fold_positive, cfd_time, timestamp,
           rf_present, rf_time, read_bin,
    output ready
  );
endinterface

interface rtdh_rsp_if;
  import rtdh_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [BIN_INDEX_W-1:0] bin_index;
  logic                   counted;
  logic [COUNT_W-1:0]     bin_count;

  modport source (output valid, bin_index, counted, bin_count, input ready);
  modport sink   (input valid, bin_index, counted, bin_count, output ready);
endinterface

[hdl/rtdh_bin.sv]
// Bin selection from CFD time, timestamp and RF reference.
`timescale 1ns / 1ps
module rtdh_bin #(
  parameter int BINS  = rtdh_pkg::BINS_DEFAULT,
  parameter int BIN_W = $clog2(BINS)
) (
  input  logic [rtdh_pkg::TIME_W-1:0]        cfd_time,
  input  logic [rtdh_pkg::TS_W-1:0]          timestamp,
  input  logic                               rf_present,
  input  logic signed [rtdh_pkg::TIME_W-1:0] rf_time,
  output logic [BIN_W-1:0]                   bin
);
  import rtdh_pkg::*;

  localparam int DIFF_W = TIME_W + 3;
  localparam logic signed [DIFF_W-1:0] HALF   = DIFF_W'(BINS / 2);
  localparam logic signed [DIFF_W-1:0] BINS_S = DIFF_W'(BINS);
  localparam logic [BIN_W-1:0] BIN_UNDER = BIN_W'(BINS - 2);
  localparam logic [BIN_W-1:0] BIN_OVER  = BIN_W'(BINS - 3);
  localparam logic [BIN_W-1:0] BIN_NO_RF = BIN_W'(BINS - 4);

  logic signed [DIFF_W-1:0] cfd_ext, ts_ext, t0_ext, u;

  assign cfd_ext = $signed({3'b000, cfd_time});
  assign ts_ext  = $signed({3'b000, timestamp, {TS_SHIFT{1'b0}}});
  assign t0_ext  = $signed({{3{rf_time[TIME_W-1]}}, rf_time});
  assign u       = cfd_ext - ts_ext - t0_ext + HALF;

  always_comb begin
    if (!rf_present) begin
      bin = BIN_NO_RF;
    end else if (u[DIFF_W-1]) begin
      bin = BIN_UNDER;
    end else if (u >= BINS_S) begin
      bin = BIN_OVER;
    end else begin
      bin = u[BIN_W-1:0];
    end
  end

endmodule

[hdl/rtdh_mem.sv]
// Histogram count memory: one write port, one registered read port.
`timescale 1ns / 1ps
module rtdh_mem #(
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = $clog2(DEPTH),
  parameter int DATA_W = rtdh_pkg::COUNT_W
) (
  input  logic              clk,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data
);
  import rtdh_pkg::*;

  logic [DATA_W-1:0] mem [DEPTH];

  // read-first: a read and a write to one entry in one cycle return old data
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

endmodule

[hdl/ring_time_difference_histogram_core.sv]
// Top level: per-ring time-difference histogram with read-modify-write pipeline.
`timescale 1ns / 1ps
// Usage
//   req carries one item per handshake: an accumulate (one ring hit) or a read
//   of one bin. rsp returns exactly one item for every req item, in order.
//   Accumulate: the bin comes from cfd_time - 16*timestamp, minus
//   rf_time plus BINS/2, clamped to the special bins BINS-2 (under) and
//   BINS-3 (over); BINS-4 without RF. The ring's bin count is incremented
//   with saturation and the new count is returned with counted = 1. Hits on
//   ring 0, rings >= RINGS, or without hit/fold return all zeros.
//   Read: returns the stored count, zero for out-of-range ring or bin.
// Timing
//   Three stages: capture, memory read, increment/write-back into the output
//   register. rsp.valid rises when the item has passed capture and memory read
//   into the output register; one item per cycle is sustained while rsp.ready
//   is high. The single-port-read memory's registered read is covered by
//   forwarding from the output stage when consecutive items hit the same entry.
// Reset
//   rst clears the pipeline and starts a clearing pass that writes zero to
//   every entry, RINGS * 2^clog2(BINS) entries in all (786432 at the defaults).
//   req.ready stays low until the pass is done.
// Backpressure
//   When rsp.ready is low with a result waiting, the whole pipeline holds and
//   req.ready drops; no item is lost or repeated.
module ring_time_difference_histogram_core #(
  parameter int RINGS = rtdh_pkg::RINGS_DEFAULT,
  parameter int BINS  = rtdh_pkg::BINS_DEFAULT
) (
  input logic        clk,
  input logic        rst,
  rtdh_req_if.sink   req,
  rtdh_rsp_if.source rsp
);
  import rtdh_pkg::*;

  localparam int BIN_W      = $clog2(BINS);
  localparam int RING_W     = $clog2(RINGS);
  localparam int ADDR_W     = RING_W + BIN_W;
  localparam int DEPTH      = RINGS * (2 ** BIN_W);
  localparam int RING_CMP_W = RING_IN_W + 1;
  localparam int BIN_CMP_W  = READ_BIN_W + 2;
  localparam logic [ADDR_W-1:0] CLEAR_LAST = ADDR_W'(DEPTH - 1);

  // clearing sequencer
  state_t            state, state_next;
  logic [ADDR_W-1:0] clear_addr;
  logic              clearing;

  // pipeline
  logic   advance;
  logic   s0_valid;
  req_t   s0;
  logic   s1_valid;
  logic   s1_count_en;
  logic   s1_read_ok;
  logic [ADDR_W-1:0]      s1_addr;
  logic [BIN_INDEX_W-1:0] s1_bin_index;
  logic   s2_valid;
  logic   s2_counted;
  logic [ADDR_W-1:0]      s2_addr;
  logic [COUNT_W-1:0]     s2_count;
  logic [BIN_INDEX_W-1:0] s2_bin_index;

  // stage 0 decode
  logic [BIN_W-1:0]       bin_sel;
  logic [BIN_W-1:0]       addr_bin;
  logic                   ring_lt;
  logic                   s0_count_en;
  logic                   s0_read_ok;
  logic [ADDR_W-1:0]      s0_addr;
  logic [BIN_INDEX_W-1:0] s0_bin_index;

  // stage 1 update
  logic [COUNT_W-1:0] rd_data;
  logic [COUNT_W-1:0] base;
  logic [COUNT_W-1:0] incr;
  logic [COUNT_W-1:0] s1_result;

  // memory ports
  logic              rd_en;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [COUNT_W-1:0] wr_data;

  // ---------------- clearing sequencer ----------------
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: if (clear_addr == CLEAR_LAST) state_next = ST_RUN;
      ST_RUN:   state_next = ST_RUN;
      default:  state_next = ST_CLEAR;
    endcase
  end

  always_comb begin
    case (state)
      ST_CLEAR: clearing = 1'b1;
      ST_RUN:   clearing = 1'b0;
      default:  clearing = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      clear_addr <= '0;
    end else begin
      state <= state_next;
      if (clearing) begin
        clear_addr <= clear_addr + ADDR_W'(1);
      end
    end
  end

  // ---------------- handshake ----------------
  // the whole pipeline moves together; it holds only when a result waits and rsp.ready is low
  assign advance   = !s2_valid || rsp.ready;
  assign req.ready = advance && !clearing;

  // ---------------- stage 0: capture ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (advance) begin
      s0_valid <= req.valid && req.ready;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s0.operation     <= req.operation;
      s0.ring          <= req.ring;
      s0.ring_hit      <= req.ring_hit;
      s0.fold_positive <= req.fold_positive;
      s0.cfd_time      <= req.cfd_time;
      s0.timestamp     <= req.timestamp;
      s0.rf_present    <= req.rf_present;
      s0.rf_time       <= req.rf_time;
      s0.read_bin      <= req.read_bin;
    end
  end

  rtdh_bin #(
    .BINS  (BINS),
    .BIN_W (BIN_W)
  ) u_bin (
    .cfd_time   (s0.cfd_time),
    .timestamp  (s0.timestamp),
    .rf_present (s0.rf_present),
    .rf_time    ($signed(s0.rf_time)),
    .bin        (bin_sel)
  );

  // ring 0 is never counted; ring >= RINGS has no storage
  assign ring_lt     = {1'b0, s0.ring} < RING_CMP_W'(RINGS);
  assign s0_count_en = (s0.operation == OP_ACCUM) && s0.ring_hit && s0.fold_positive &&
                       (s0.ring != '0) && ring_lt;
  assign s0_read_ok  = (s0.operation == OP_READ) && ring_lt &&
                       ({2'b00, s0.read_bin} < BIN_CMP_W'(BINS));
  assign addr_bin    = (s0.operation == OP_READ) ? BIN_W'(s0.read_bin) : bin_sel;
  assign s0_addr     = {s0.ring[RING_W-1:0], addr_bin};

  always_comb begin
    if (s0_count_en) begin
      s0_bin_index = BIN_INDEX_W'(bin_sel);
    end else if (s0.operation == OP_READ) begin
      s0_bin_index = s0.read_bin;
    end else begin
      s0_bin_index = '0;
    end
  end

  // ---------------- stage 1: memory read ----------------
  assign rd_en = advance && s0_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= s0_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_count_en  <= s0_count_en;
      s1_read_ok   <= s0_read_ok;
      s1_addr      <= s0_addr;
      s1_bin_index <= s0_bin_index;
    end
  end

  // The output stage wrote its entry on the same edge that stage 1 read,
  // so the memory returned the old count: take the fresh one instead.
  assign base = (s2_valid && s2_counted && (s2_addr == s1_addr)) ? s2_count : rd_data;
  assign incr = (base == COUNT_MAX) ? base : base + COUNT_W'(1);

  always_comb begin
    if (s1_count_en) begin
      s1_result = incr;
    end else if (s1_read_ok) begin
      s1_result = base;
    end else begin
      s1_result = '0;
    end
  end

  // write port: clearing pass, else the increment write-back
  assign wr_en   = clearing || (advance && s1_valid && s1_count_en);
  assign wr_addr = clearing ? clear_addr : s1_addr;
  assign wr_data = clearing ? '0 : incr;

  rtdh_mem #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W),
    .DATA_W (COUNT_W)
  ) u_mem (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (s0_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  // ---------------- stage 2: output register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (advance) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s2_counted   <= s1_count_en;
      s2_addr      <= s1_addr;
      s2_count     <= s1_result;
      s2_bin_index <= s1_bin_index;
    end
  end

  assign rsp.valid     = s2_valid;
  assign rsp.counted   = s2_counted;
  assign rsp.bin_count = s2_count;
  assign rsp.bin_index = s2_bin_index;

  // ---------------- assertions ----------------
  // pipeline is empty for the whole clearing pass
  a_clear_empty: assert property (@(posedge clk) disable iff (rst)
    clearing |-> (!s0_valid && !s1_valid && !s2_valid))
    else $error("item in flight during clearing pass");

  // a counted result is at least one, forwarding included
  a_counted_nonzero: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.counted) |-> (rsp.bin_count != '0))
    else $error("counted result with zero count");

  // ring 0 entries are never incremented
  a_ring0_untouched: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_count_en) |-> (s1_addr[ADDR_W-1:BIN_W] != '0))
    else $error("increment aimed at ring 0");

  // no increment write-back reaches the memory while the pipeline stalls
  a_stall_no_write: assert property (@(posedge clk) disable iff (rst)
    (!clearing && !advance) |-> !wr_en)
    else $error("memory write while pipeline stalled");

endmodule
